// ----- hw/rtl/vgm_csf_pkg.sv -----
// ----------------------------------------------------------------------------
// vgm_csf_pkg
// shared types, constants and the operand length table of the forwarder
// ----------------------------------------------------------------------------
package vgm_csf_pkg;

  localparam int TIME_WIDTH = 48;

  // command codes
  localparam logic [7:0] CMD_WRITE_B4  = 8'hB4;
  localparam logic [7:0] CMD_WRITE_51  = 8'h51;
  localparam logic [7:0] CMD_WAIT_N    = 8'h61;
  localparam logic [7:0] CMD_WAIT_735  = 8'h62;
  localparam logic [7:0] CMD_WAIT_882  = 8'h63;
  localparam logic [7:0] CMD_END       = 8'h66;
  localparam logic [7:0] CMD_BLOCK     = 8'h67;
  localparam logic [3:0] CMD_WAIT_SHORT_HI = 4'h7;
  localparam logic [7:0] BLOCK_TYPE_FWD = 8'hC2;

  localparam logic [15:0] WAIT_735 = 16'd735;
  localparam logic [15:0] WAIT_882 = 16'd882;

  // paired expansion registers whose low address bits swap
  localparam logic [15:0] ADDR_9001 = 16'h9001;
  localparam logic [15:0] ADDR_9002 = 16'h9002;
  localparam logic [15:0] ADDR_A001 = 16'hA001;
  localparam logic [15:0] ADDR_A002 = 16'hA002;
  localparam logic [15:0] ADDR_B001 = 16'hB001;
  localparam logic [15:0] ADDR_B002 = 16'hB002;
  localparam logic [15:0] ADDR_KEEP_MASK = 16'hFFFC;
  localparam logic [15:0] ADDR_SWAP_MASK = 16'h0003;

  localparam logic [31:0] SWAP_BLOCK_SIZE = 32'd3;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_WAIT = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_CMD     = 4'd0,
    PH_FWD     = 4'd1,
    PH_SKIP    = 4'd2,
    PH_WLO     = 4'd3,
    PH_WHI     = 4'd4,
    PH_BSECOND = 4'd5,
    PH_BTYPE   = 4'd6,
    PH_BSIZE0  = 4'd7,
    PH_BSIZE1  = 4'd8,
    PH_BSIZE2  = 4'd9,
    PH_BSIZE3  = 4'd10,
    PH_BDATA   = 4'd11,
    PH_ADDRHI  = 4'd12,
    PH_ENDED   = 4'd13
  } phase_t;

  // results caused by one input transfer, first result in bytes[0]
  typedef struct packed {
    logic [1:0]            count;
    kind_t                 kind;
    logic [2:0][7:0]       bytes;
    logic [TIME_WIDTH-1:0] time_val;
  } bundle_t;

  // operand bytes that follow a skipped command
  function automatic logic [3:0] operand_count(input logic [7:0] c);
    logic [3:0] r;
    if (c < 8'h30)                             r = 4'd0;
    else if (c < 8'h40)                        r = 4'd1;
    else if (c < 8'h4F)                        r = 4'd2;
    else if (c <= 8'h50)                       r = 4'd1;
    else if (c < 8'h60)                        r = 4'd2;
    else if (c == 8'h61)                       r = 4'd2;
    else if (c == 8'h67)                       r = 4'd6;
    else if (c == 8'h68)                       r = 4'd11;
    else if (c < 8'h90)                        r = 4'd0;
    else if (c == 8'h90 || c == 8'h91 || c == 8'h95) r = 4'd4;
    else if (c == 8'h92)                       r = 4'd5;
    else if (c == 8'h93)                       r = 4'd10;
    else if (c == 8'h94)                       r = 4'd1;
    else if (c < 8'hA0)                        r = 4'd0;
    else if (c < 8'hC0)                        r = 4'd2;
    else if (c < 8'hE0)                        r = 4'd3;
    else                                       r = 4'd4;
    return r;
  endfunction

endpackage

// ----- hw/rtl/vgm_csf_if.sv -----
// ----------------------------------------------------------------------------
// vgm_csf channel interfaces
// stream byte channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface vgm_csf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       pass_start;

  modport source (output valid, output data_byte, output pass_start, input ready);
  modport sink   (input valid, input data_byte, input pass_start, output ready);
endinterface

interface vgm_csf_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic [7:0]                        out_byte;
  logic [vgm_csf_pkg::TIME_WIDTH-1:0] target_time;
  logic                              last_of_run;

  modport source (output valid, output kind, output out_byte, output target_time,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input out_byte, input target_time,
                  input last_of_run, output ready);
endinterface

// ----- hw/rtl/vgm_csf_parser.sv -----
// ----------------------------------------------------------------------------
// vgm_csf_parser
// per-byte command decode, parser state and result bundle generation
// ----------------------------------------------------------------------------
module vgm_csf_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic                   cfg_write_data,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   pass_start,
  output vgm_csf_pkg::bundle_t   bundle
);

  logic                              swap_mode;
  vgm_csf_pkg::phase_t               phase, phase_next, phase_eff;
  logic [7:0]                        header_second, header_second_next;
  logic [31:0]                       block_size, block_size_next;
  logic [31:0]                       bytes_left, bytes_left_next, bytes_left_dec;
  logic [7:0]                        held_address_low, held_address_low_next;
  logic [7:0]                        wait_low, wait_low_next;
  logic [vgm_csf_pkg::TIME_WIDTH-1:0] sample_time, sample_time_next;
  logic [15:0]                       wait_add;
  logic                              add_en;
  logic [15:0]                       addr, addr_out;
  logic [31:0]                       size_full;
  logic [3:0]                        ops;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_mode <= 1'b0;
    end else if (cfg_write_en) begin
      swap_mode <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= vgm_csf_pkg::PH_CMD;
      header_second    <= '0;
      block_size       <= '0;
      bytes_left       <= '0;
      held_address_low <= '0;
      wait_low         <= '0;
      sample_time      <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      header_second    <= header_second_next;
      block_size       <= block_size_next;
      bytes_left       <= bytes_left_next;
      held_address_low <= held_address_low_next;
      wait_low         <= wait_low_next;
      sample_time      <= sample_time_next;
    end
  end

  assign phase_eff      = pass_start ? vgm_csf_pkg::PH_CMD : phase;
  assign bytes_left_dec = bytes_left - 32'd1;
  assign addr           = {data_byte, held_address_low};
  assign size_full      = {data_byte, block_size[23:0]};
  assign ops            = vgm_csf_pkg::operand_count(data_byte);

  // address swap for the paired expansion registers
  always_comb begin
    addr_out = addr;
    if (addr == vgm_csf_pkg::ADDR_9001 || addr == vgm_csf_pkg::ADDR_9002 ||
        addr == vgm_csf_pkg::ADDR_A001 || addr == vgm_csf_pkg::ADDR_A002 ||
        addr == vgm_csf_pkg::ADDR_B001 || addr == vgm_csf_pkg::ADDR_B002) begin
      addr_out = (addr & vgm_csf_pkg::ADDR_KEEP_MASK) | (~addr & vgm_csf_pkg::ADDR_SWAP_MASK);
    end
  end

  always_comb begin
    phase_next            = phase_eff;
    header_second_next    = header_second;
    block_size_next       = block_size;
    bytes_left_next       = bytes_left;
    held_address_low_next = held_address_low;
    wait_low_next         = wait_low;
    wait_add              = '0;
    add_en                = 1'b0;
    bundle.count          = 2'd0;
    bundle.kind           = vgm_csf_pkg::KIND_BYTE;
    bundle.bytes          = '0;

    unique case (phase_eff)
      vgm_csf_pkg::PH_FWD: begin
        bundle.count    = 2'd1;
        bundle.bytes[0] = data_byte;
        bytes_left_next = bytes_left_dec;
        if (bytes_left_dec == '0) phase_next = vgm_csf_pkg::PH_CMD;
      end
      vgm_csf_pkg::PH_SKIP: begin
        bytes_left_next = bytes_left_dec;
        if (bytes_left_dec == '0) phase_next = vgm_csf_pkg::PH_CMD;
      end
      vgm_csf_pkg::PH_WLO: begin
        wait_low_next = data_byte;
        phase_next    = vgm_csf_pkg::PH_WHI;
      end
      vgm_csf_pkg::PH_WHI: begin
        wait_add     = {data_byte, wait_low};
        add_en       = 1'b1;
        bundle.count = 2'd1;
        bundle.kind  = vgm_csf_pkg::KIND_WAIT;
        phase_next   = vgm_csf_pkg::PH_CMD;
      end
      vgm_csf_pkg::PH_BSECOND: begin
        header_second_next = data_byte;
        phase_next         = vgm_csf_pkg::PH_BTYPE;
      end
      vgm_csf_pkg::PH_BTYPE: begin
        // for a forwarded block type the held header goes out with the type byte
        if (data_byte == vgm_csf_pkg::BLOCK_TYPE_FWD) begin
          bundle.count    = 2'd3;
          bundle.bytes[0] = vgm_csf_pkg::CMD_BLOCK;
          bundle.bytes[1] = header_second;
          bundle.bytes[2] = data_byte;
        end
        header_second_next = data_byte;
        block_size_next    = '0;
        phase_next         = vgm_csf_pkg::PH_BSIZE0;
      end
      vgm_csf_pkg::PH_BSIZE0, vgm_csf_pkg::PH_BSIZE1,
      vgm_csf_pkg::PH_BSIZE2, vgm_csf_pkg::PH_BSIZE3: begin
        if (header_second == vgm_csf_pkg::BLOCK_TYPE_FWD) begin
          bundle.count    = 2'd1;
          bundle.bytes[0] = data_byte;
        end
        case (phase_eff)
          vgm_csf_pkg::PH_BSIZE0: begin
            block_size_next[7:0] = data_byte;
            phase_next           = vgm_csf_pkg::PH_BSIZE1;
          end
          vgm_csf_pkg::PH_BSIZE1: begin
            block_size_next[15:8] = data_byte;
            phase_next            = vgm_csf_pkg::PH_BSIZE2;
          end
          vgm_csf_pkg::PH_BSIZE2: begin
            block_size_next[23:16] = data_byte;
            phase_next             = vgm_csf_pkg::PH_BSIZE3;
          end
          default: begin
            block_size_next = size_full;
            bytes_left_next = size_full;
            if (size_full == '0) phase_next = vgm_csf_pkg::PH_CMD;
            else if (header_second == vgm_csf_pkg::BLOCK_TYPE_FWD)
              phase_next = vgm_csf_pkg::PH_BDATA;
            else phase_next = vgm_csf_pkg::PH_SKIP;
          end
        endcase
      end
      vgm_csf_pkg::PH_BDATA: begin
        bytes_left_next = bytes_left_dec;
        if (bytes_left == block_size && block_size == vgm_csf_pkg::SWAP_BLOCK_SIZE &&
            swap_mode) begin
          held_address_low_next = data_byte;
          phase_next            = vgm_csf_pkg::PH_ADDRHI;
        end else begin
          bundle.count    = 2'd1;
          bundle.bytes[0] = data_byte;
          if (bytes_left_dec == '0) phase_next = vgm_csf_pkg::PH_CMD;
        end
      end
      vgm_csf_pkg::PH_ADDRHI: begin
        bundle.count    = 2'd2;
        bundle.bytes[0] = addr_out[7:0];
        bundle.bytes[1] = addr_out[15:8];
        bytes_left_next = bytes_left_dec;
        phase_next = (bytes_left_dec == '0) ? vgm_csf_pkg::PH_CMD : vgm_csf_pkg::PH_BDATA;
      end
      vgm_csf_pkg::PH_ENDED: begin
      end
      default: begin
        // command byte
        phase_next = vgm_csf_pkg::PH_CMD;
        if (data_byte == vgm_csf_pkg::CMD_WRITE_B4 || data_byte == vgm_csf_pkg::CMD_WRITE_51) begin
          bundle.count    = 2'd1;
          bundle.bytes[0] = data_byte;
          bytes_left_next = 32'd2;
          phase_next      = vgm_csf_pkg::PH_FWD;
        end else if (data_byte == vgm_csf_pkg::CMD_WAIT_N) begin
          phase_next = vgm_csf_pkg::PH_WLO;
        end else if (data_byte == vgm_csf_pkg::CMD_WAIT_735) begin
          wait_add     = vgm_csf_pkg::WAIT_735;
          add_en       = 1'b1;
          bundle.count = 2'd1;
          bundle.kind  = vgm_csf_pkg::KIND_WAIT;
        end else if (data_byte == vgm_csf_pkg::CMD_WAIT_882) begin
          wait_add     = vgm_csf_pkg::WAIT_882;
          add_en       = 1'b1;
          bundle.count = 2'd1;
          bundle.kind  = vgm_csf_pkg::KIND_WAIT;
        end else if (data_byte == vgm_csf_pkg::CMD_END) begin
          bundle.count = 2'd1;
          bundle.kind  = vgm_csf_pkg::KIND_END;
          phase_next   = vgm_csf_pkg::PH_ENDED;
        end else if (data_byte == vgm_csf_pkg::CMD_BLOCK) begin
          phase_next = vgm_csf_pkg::PH_BSECOND;
        end else if (data_byte[7:4] == vgm_csf_pkg::CMD_WAIT_SHORT_HI) begin
          wait_add     = {12'd0, data_byte[3:0]} + 16'd1;
          add_en       = 1'b1;
          bundle.count = 2'd1;
          bundle.kind  = vgm_csf_pkg::KIND_WAIT;
        end else begin
          bytes_left_next = {28'd0, ops};
          if (ops != '0) phase_next = vgm_csf_pkg::PH_SKIP;
        end
      end
    endcase

    // running sample time, results carry the time after this byte
    sample_time_next = add_en
        ? sample_time + {{(vgm_csf_pkg::TIME_WIDTH-16){1'b0}}, wait_add}
        : sample_time;
    bundle.time_val  = sample_time_next;
  end

endmodule

// ----- hw/rtl/vgm_csf_serializer.sv -----
// ----------------------------------------------------------------------------
// vgm_csf_serializer
// result register: holds one bundle and sends its results one per transfer
// ----------------------------------------------------------------------------
module vgm_csf_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  vgm_csf_pkg::bundle_t bundle,
  output logic                 load_ok,
  vgm_csf_out_if.source        res_out
);

  logic [1:0]                        cnt, cnt_next;
  logic [2:0][7:0]                   bytes;
  vgm_csf_pkg::kind_t                kind;
  logic [vgm_csf_pkg::TIME_WIDTH-1:0] time_val;
  logic                              xfer;

  assign xfer    = res_out.valid && res_out.ready;
  // a new bundle fits once the last result of the held one leaves
  assign load_ok = (cnt == 2'd0) || (cnt == 2'd1 && res_out.ready);

  always_comb begin
    cnt_next = cnt;
    if (accept) cnt_next = bundle.count;
    else if (xfer) cnt_next = cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bytes    <= bundle.bytes;
      kind     <= bundle.kind;
      time_val <= bundle.time_val;
    end else if (xfer) begin
      bytes <= {8'd0, bytes[2], bytes[1]};
    end
  end

  assign res_out.valid       = (cnt != 2'd0);
  assign res_out.kind        = kind;
  assign res_out.out_byte    = bytes[0];
  assign res_out.target_time = time_val;
  assign res_out.last_of_run = (cnt == 2'd1);

  a_no_load_mid_run: assert property (@(posedge clk) disable iff (rst)
    (cnt >= 2'd2) |-> !load_ok)
    else $error("new bundle offered while results remain");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (xfer && !res_out.last_of_run) |=> res_out.valid)
    else $error("run stopped before its last result");

  a_empty_load: assert property (@(posedge clk) disable iff (rst)
    (accept && bundle.count == 2'd0) |=> !res_out.valid)
    else $error("result shown for a transfer that caused none");

  a_single_non_byte: assert property (@(posedge clk) disable iff (rst)
    (accept && bundle.count != 2'd0 && bundle.kind != vgm_csf_pkg::KIND_BYTE)
      |=> (res_out.valid && res_out.last_of_run))
    else $error("wait or end result not alone in its run");

endmodule

// ----- hw/rtl/vgm_command_stream_forwarder.sv -----
// ----------------------------------------------------------------------------
// vgm_command_stream_forwarder
// byte-wide command stream parser forwarding sound writes and wait targets
// ----------------------------------------------------------------------------
// usage
//   cmd_in  : one stream byte per transfer; pass_start high on the first byte
//             of a pass restarts the parser at that byte, sample time is kept
//   res_out : results, one per transfer; kind byte / wait target / end of
//             pass, last_of_run high on the final result of a stream byte
//   cfg_*   : swap_mode, written while the block is idle
// latency: a byte's first result is shown the cycle after its transfer
// throughput: one byte per cycle while no byte causes over one result and
//   res_out.ready is high; a byte with more results holds cmd_in until its
//   last one shows, the one result register draining one result per transfer
// stall: while res_out is stalled on a result that is not the last of its
//   run, cmd_in.ready is low; on the last one a new byte is taken as soon as
//   res_out.ready rises, so the two sides overlap
// reset: rst (synchronous) empties the result register, clears the parser
//   to expect a command byte, zeroes the sample time and clears swap_mode
// ----------------------------------------------------------------------------
module vgm_command_stream_forwarder (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write_en,
  input  logic          cfg_write_data,
  vgm_csf_in_if.sink    cmd_in,
  vgm_csf_out_if.source res_out
);

  vgm_csf_pkg::bundle_t bundle;  // results of the byte being taken
  logic                 load_ok; // result register can take a bundle
  logic                 accept;  // input transfer

  assign cmd_in.ready = load_ok;
  assign accept       = cmd_in.valid && load_ok;

  // decode and parser state, advanced once per input transfer
  vgm_csf_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .accept         (accept),
    .data_byte      (cmd_in.data_byte),
    .pass_start     (cmd_in.pass_start),
    .bundle         (bundle)
  );

  // result register, sends a bundle out one result at a time
  vgm_csf_serializer u_serializer (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .bundle  (bundle),
    .load_ok (load_ok),
    .res_out (res_out)
  );

endmodule
